/* hw/rtl/nmtws_pkg.sv */
package nmtws_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;
    localparam int MAX_RADIUS = 15;

    localparam int FIELD_W = 8;
    localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
    localparam int DY_W    = RAD_W + 1;
    localparam int WIN     = 2 * MAX_RADIUS + 1;
    localparam int D_W     = $clog2(2 * MAX_RADIUS + 1);
    localparam int ROW_AW  = $clog2(MAP_HEIGHT);
    localparam int COL_AW  = $clog2(MAP_WIDTH);

    // signed coordinate width: holds centre +/- radius and the map size
    localparam int CW_A = (FIELD_W > RAD_W) ? FIELD_W : RAD_W;
    localparam int CW_B = (ROW_AW > COL_AW) ? ROW_AW : COL_AW;
    localparam int C_W  = ((CW_A > CW_B) ? CW_A : CW_B) + 2;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] search_radius;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] found_col;
        logic [7:0] found_row;
        logic [4:0] distance;
    } t_out_item;

    typedef struct packed {
        logic [7:0]       col;
        logic [7:0]       row;
        logic [RAD_W-1:0] rad;
    } t_query;

    typedef struct packed {
        logic                   valid;
        logic                   live;
        logic signed [DY_W-1:0] dy;
    } t_row_ctl;

    typedef struct packed {
        logic                  have;
        logic signed [C_W-1:0] x;
        logic signed [C_W-1:0] y;
        logic [D_W-1:0]        d;
    } t_best;

endpackage

/* hw/rtl/nmtws_ram.sv */
module nmtws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/nmtws_row_unit.sv */
module nmtws_row_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  nmtws_pkg::t_row_ctl                 i_ctl,
    input  logic [nmtws_pkg::MAP_WIDTH-1:0]     i_rd_data,
    input  nmtws_pkg::t_query                   i_query,
    output logic                                o_busy,
    output nmtws_pkg::t_best                    o_best
);
    import nmtws_pkg::*;

    localparam int EXT_W = MAP_WIDTH + WIN + MAX_RADIUS;

    // stage 1: window bits of the row, stage 2: nearest in row and running best
    logic [WIN-1:0]         r_win;
    logic                   r_v1;
    logic signed [DY_W-1:0] r_dy1;
    t_best                  r_best;

    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] shifted;
    logic [WIN-1:0]   mask;

    always_comb begin
        ext     = {{WIN{1'b0}}, i_rd_data, {MAX_RADIUS{1'b0}}};
        shifted = ext >> i_query.col;
        for (int k = 0; k < WIN; k++) begin
            mask[k] = (k >= MAX_RADIUS - int'(i_query.rad)) &&
                      (k <= MAX_RADIUS + int'(i_query.rad));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.valid;
        end
        r_dy1 <= i_ctl.dy;
        r_win <= i_ctl.live ? (shifted[WIN-1:0] & mask) : '0;
    end

    logic                   l_hit, rt_hit, pick_left, row_hit;
    logic [RAD_W-1:0]       l_pos, rt_pos, adx, ady;
    logic signed [C_W-1:0]  sdx, dy_ext, cx_ext, cy_ext, nx, ny;
    logic [D_W-1:0]         nd;

    always_comb begin
        // right half (dx >= 0): nearest set bit from the centre outwards
        rt_hit = 1'b0;
        rt_pos = '0;
        for (int i = MAX_RADIUS; i >= 0; i--) begin
            if (r_win[MAX_RADIUS + i]) begin
                rt_hit = 1'b1;
                rt_pos = RAD_W'(i);
            end
        end
        // left half (dx < 0)
        l_hit = 1'b0;
        l_pos = '0;
        for (int i = MAX_RADIUS; i >= 1; i--) begin
            if (r_win[MAX_RADIUS - i]) begin
                l_hit = 1'b1;
                l_pos = RAD_W'(i);
            end
        end
        // left is met first in scan order, so it wins ties
        pick_left = l_hit && (!rt_hit || (l_pos <= rt_pos));
        row_hit   = l_hit || rt_hit;
        adx       = pick_left ? l_pos : rt_pos;
        ady       = r_dy1[DY_W-1] ? RAD_W'(-r_dy1) : RAD_W'(r_dy1);
        sdx       = pick_left ? -$signed({{(C_W-RAD_W){1'b0}}, adx})
                              : $signed({{(C_W-RAD_W){1'b0}}, adx});
        dy_ext    = {{(C_W-DY_W){r_dy1[DY_W-1]}}, r_dy1};
        cx_ext    = $signed({{(C_W-FIELD_W){1'b0}}, i_query.col});
        cy_ext    = $signed({{(C_W-FIELD_W){1'b0}}, i_query.row});
        nx        = cx_ext + sdx;
        ny        = cy_ext + dy_ext;
        nd        = D_W'(adx) + D_W'(ady);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.have <= 1'b0;
        end else if (i_start) begin
            r_best.have <= 1'b0;
        end else if (r_v1 && row_hit && (!r_best.have || (nd < r_best.d))) begin
            r_best.have <= 1'b1;
        end
        if (r_v1 && row_hit && (!r_best.have || (nd < r_best.d))) begin
            r_best.x <= nx;
            r_best.y <= ny;
            r_best.d <= nd;
        end
    end

    assign o_busy = i_ctl.valid || r_v1;
    assign o_best = r_best;

endmodule

/* hw/rtl/nearest_marked_tile_window_search.sv */
// Nearest marked tile search over a one-bit occupancy map.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one transaction:
//   clear  - empties the map by clearing its row-valid flags, no result
//   mark   - sets one tile (row read then row write), no result;
//            a tile outside the map is ignored
//   query  - scans the window around (col,row), one map row per cycle through
//            a single row-evaluation unit, and returns one result
// Output channel (o_out_valid / i_out_ready / o_out_data) carries query results.
// A query with radius r (saturated at the maximum radius) holds the input side
// off until its result is registered; how long that takes is set by the single
// RAM port reading one window row per cycle plus a three-stage read/extract/compare pipe.
// The result sits in an output register: marks and clears are still taken
// while it waits, and a later query holds at its end until the register frees.
// Reset clears every row-valid flag, so the map reads empty at once; there is
// no clearing pass and the block is ready as soon as reset is released.
module nearest_marked_tile_window_search (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  nmtws_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output nmtws_pkg::t_out_item  o_out_data
);
    import nmtws_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_MARK_WR = 2'd1;
    localparam logic [1:0] S_SCAN    = 2'd2;
    localparam logic [1:0] S_DRAIN   = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [MAP_HEIGHT-1:0]   r_row_valid;
    logic [ROW_AW-1:0]       r_row_addr;
    logic [7:0]              r_col;
    t_query                  r_query;
    logic signed [DY_W-1:0]  r_dy;
    t_row_ctl                r_rd_ctl;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_acc;
    logic                    ram_we;
    logic [ROW_AW-1:0]       ram_addr;
    logic [MAP_WIDTH-1:0]    ram_wdata, ram_rdata;
    logic signed [C_W-1:0]   in_row_ext, scan_y;
    logic                    scan_in_map;
    logic [RAD_W-1:0]        in_rad;
    logic                    out_free;
    logic                    u_busy;
    t_best                   u_best;
    logic [31:0]             d_ext;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        in_row_ext  = $signed({{(C_W-FIELD_W){1'b0}}, i_in_data.row});
        scan_y      = $signed({{(C_W-FIELD_W){1'b0}}, r_query.row}) +
                      {{(C_W-DY_W){r_dy[DY_W-1]}}, r_dy};
        scan_in_map = !scan_y[C_W-1] && (scan_y < C_W'(MAP_HEIGHT));
        in_rad      = (int'(i_in_data.search_radius) > MAX_RADIUS) ?
                      RAD_W'(MAX_RADIUS) : RAD_W'(i_in_data.search_radius);
        d_ext       = 32'(u_best.d);
    end

    // RAM port: input row while idle, so a mark has its row read at acceptance
    always_comb begin
        ram_we    = (r_state == S_MARK_WR);
        ram_wdata = (r_row_valid[r_row_addr] ? ram_rdata : '0) |
                    (MAP_WIDTH'(1) << r_col);
        case (r_state)
            S_MARK_WR: ram_addr = r_row_addr;
            S_SCAN:    ram_addr = scan_y[ROW_AW-1:0];
            default:   ram_addr = in_row_ext[ROW_AW-1:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        OP_MARK: begin
                            if ((int'(i_in_data.col) < MAP_WIDTH) &&
                                (int'(i_in_data.row) < MAP_HEIGHT)) begin
                                n_state = S_MARK_WR;
                            end
                        end
                        OP_QUERY: n_state = S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_MARK_WR: n_state = S_IDLE;
            S_SCAN: begin
                if (r_dy == $signed({1'b0, r_query.rad})) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!u_busy && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_row_valid    <= '0;
            r_rd_ctl.valid <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_rd_ctl.valid <= (r_state == S_SCAN);
            if (in_acc && (i_in_data.op == OP_CLEAR)) begin
                r_row_valid <= '0;
            end else if (ram_we) begin
                r_row_valid[r_row_addr] <= 1'b1;
            end
            if (r_state == S_DRAIN && !u_busy && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        r_rd_ctl.dy   <= r_dy;
        r_rd_ctl.live <= scan_in_map && r_row_valid[scan_y[ROW_AW-1:0]];

        if (in_acc) begin
            r_row_addr    <= in_row_ext[ROW_AW-1:0];
            r_col         <= i_in_data.col;
            r_query.col   <= i_in_data.col;
            r_query.row   <= i_in_data.row;
            r_query.rad   <= in_rad;
            r_dy          <= -$signed({1'b0, in_rad});
        end else if (r_state == S_SCAN) begin
            r_dy <= r_dy + DY_W'(1);
        end

        if (r_state == S_DRAIN && !u_busy && out_free) begin
            r_out.found     <= u_best.have;
            r_out.found_col <= u_best.have ? u_best.x[7:0] : 8'd0;
            r_out.found_row <= u_best.have ? u_best.y[7:0] : 8'd0;
            r_out.distance  <= !u_best.have ? 5'd0 :
                               (d_ext > 32'd31) ? 5'd31 : d_ext[4:0];
        end
    end

    nmtws_ram #(
        .WIDTH (MAP_WIDTH),
        .DEPTH (MAP_HEIGHT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    nmtws_row_unit u_row (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && (i_in_data.op == OP_QUERY)),
        .i_ctl     (r_rd_ctl),
        .i_rd_data (ram_rdata),
        .i_query   (r_query),
        .o_busy    (u_busy),
        .o_best    (u_best)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a query holds the input side off until its result is registered
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.op == OP_QUERY)) |=> !o_in_ready)
        else $error("input taken right after a query");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |->
        (o_out_data.found_col == 8'd0 && o_out_data.found_row == 8'd0 &&
         o_out_data.distance == 5'd0))
        else $error("non-zero fields on empty result");

    a_mark_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_row_valid[$past(ram_addr)])
        else $error("written row not flagged valid");

    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_busy |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("row pipe busy outside a query");

endmodule
